// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers used by partition_fit_allocator_core.
// Define ASSERT_OFF to compile the checks out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: design/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg
// Types, field widths and codes of the partition fit allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

    localparam int KIND_W        = 1;
    localparam int BLOCK_INDEX_W = 6;
    localparam int REQ_SIZE_W    = 16;
    localparam int STATUS_W      = 2;
    localparam int PID_W         = 16;
    localparam int INT_W         = 32;
    localparam int EXT_W         = 22;
    localparam int POLICY_W      = 2;
    localparam int BCOUNT_W      = 7;
    localparam int CFG_INDEX_W   = 1;
    localparam int CFG_DATA_W    = 7;

    localparam logic [EXT_W-1:0] EXT_MAX = '1;
    localparam logic [INT_W-1:0] INT_MAX = '1;

    localparam logic [KIND_W-1:0] KIND_LOAD  = 1'b0;
    localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_LOADED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ALLOC  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOFIT  = 2'd2;

    localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd0;
    localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd1;

    localparam logic [CFG_INDEX_W-1:0] CFG_POLICY      = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_COUNT = 1'b1;

    localparam logic [BCOUNT_W-1:0] BCOUNT_RESET = 7'd64;
    localparam logic [PID_W-1:0]    PID_RESET    = 16'd1;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [BLOCK_INDEX_W-1:0] block_index;
        logic [REQ_SIZE_W-1:0]    size;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [BLOCK_INDEX_W-1:0] chosen_block;
        logic [PID_W-1:0]         process_id;
        logic [INT_W-1:0]         internal_frag;
        logic [EXT_W-1:0]         external_frag;
    } rsp_t;

    typedef struct packed {
        logic shift;
        logic wr_en;
        logic wr_taken;
    } cell_cmd_t;

    typedef struct packed {
        logic clear;
        logic step;
        logic alloc;
        logic active;
    } scan_ctl_t;

endpackage

// File: design/partition_fit_allocator_core.sv
// ----------------------------------------------------------------------------
// partition_fit_allocator_core
// Fixed-partition block allocator with best, worst and first fit placement.
// ----------------------------------------------------------------------------
// Every transaction, load or allocate, runs from acceptance through a scan and
// a DONE state before the next acceptance: the block table is a ring of
// NUM_BLOCKS cells that rotates once past a single evaluator at its head,
// one block per cycle, and the DONE state writes the chosen block back and
// registers the result. A result waiting on a stalled output does not block
// the next request from being accepted and scanned. Blocks are searched from
// index zero up to block_count (clamped to NUM_BLOCKS); a block never loaded
// reads as undefined.
`include "assert_macros.svh"

module partition_fit_allocator_core
    import pfa_pkg::*;
#(
    parameter int NUM_BLOCKS = 64,
    parameter int SIZE_BITS  = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  req_t                   req,
    output logic                   rsp_valid,
    input  logic                   rsp_stall,
    output rsp_t                   rsp,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int IdxW = $clog2(NUM_BLOCKS);
    localparam int CntW = $clog2(NUM_BLOCKS + 1);
    localparam int SumW = SIZE_BITS + IdxW;
    localparam int ExtCalcW = (SumW > EXT_W) ? SumW : EXT_W;
    localparam int BcW  = (CntW > BCOUNT_W) ? CntW : BCOUNT_W;
    localparam int SelW = (IdxW > BLOCK_INDEX_W) ? IdxW : BLOCK_INDEX_W;
    localparam logic [IdxW-1:0] CntLast = IdxW'(NUM_BLOCKS - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]               state_reg;
    logic [1:0]               state_next;
    logic [IdxW-1:0]          cnt_reg;
    logic [IdxW-1:0]          cnt_next;
    logic [KIND_W-1:0]        kind_reg;
    logic [BLOCK_INDEX_W-1:0] bidx_reg;
    logic [REQ_SIZE_W-1:0]    size_reg;
    logic [PID_W-1:0]         pid_reg;
    logic [PID_W-1:0]         next_id_reg;
    logic [PID_W-1:0]         next_id_next;
    logic [INT_W-1:0]         internal_reg;
    logic [INT_W-1:0]         internal_next;
    logic [POLICY_W-1:0]      policy_reg;
    logic [POLICY_W-1:0]      policy_next;
    logic [BCOUNT_W-1:0]      bcount_reg;
    logic [BCOUNT_W-1:0]      bcount_next;
    logic                     rsp_valid_reg;
    logic                     rsp_valid_next;
    rsp_t                     rsp_reg;
    rsp_t                     rsp_next;

    logic                     req_acc;
    logic                     is_alloc;
    logic                     done_fire;
    logic                     fin_wr;
    logic                     load_wr;
    logic [CntW-1:0]          n_eff;
    logic [BcW-1:0]           bcount_ext;

    logic [SIZE_BITS-1:0]     cell_left  [NUM_BLOCKS];
    logic                     cell_taken [NUM_BLOCKS];
    logic [SIZE_BITS-1:0]     wr_left;

    scan_ctl_t                scan_ctl;
    logic                     found;
    logic [IdxW-1:0]          best_idx;
    logic [SIZE_BITS-1:0]     best_left;
    logic [SumW-1:0]          sum;

    logic [ExtCalcW-1:0]      ext_exact;
    logic [EXT_W-1:0]         ext_sat;
    logic [INT_W:0]           int_sum;
    logic [INT_W-1:0]         int_sat;

    assign req_acc   = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign is_alloc  = (kind_reg == KIND_ALLOC);
    assign done_fire = (state_reg == S_DONE) && (!rsp_valid_reg || !rsp_stall);
    assign fin_wr    = done_fire && is_alloc && found;
    assign load_wr   = req_acc && (req.kind == KIND_LOAD);

    // Clamp block_count to the table size
    assign bcount_ext = BcW'(bcount_reg);
    assign n_eff = (bcount_ext > BcW'(NUM_BLOCKS)) ? CntW'(NUM_BLOCKS) : CntW'(bcount_ext);

    assign wr_left = fin_wr ? best_left : SIZE_BITS'(req.size);

    // Ring of block cells: cell i takes from cell i+1, cell 0 is the head
    for (genvar i = 0; i < NUM_BLOCKS; i++)
    begin : g_cell
        cell_cmd_t cmd;

        always_comb
        begin
            cmd.shift    = (state_reg == S_SCAN);
            cmd.wr_en    = (load_wr && (SelW'(i) == SelW'(req.block_index)))
                        || (fin_wr && (best_idx == IdxW'(i)));
            cmd.wr_taken = fin_wr;
        end

        pfa_cell #(
            .SIZE_BITS (SIZE_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .wr_left    (wr_left),
            .prev_left  (cell_left[(i + 1) % NUM_BLOCKS]),
            .prev_taken (cell_taken[(i + 1) % NUM_BLOCKS]),
            .left       (cell_left[i]),
            .taken      (cell_taken[i])
        );
    end

    always_comb
    begin
        scan_ctl.clear  = req_acc;
        scan_ctl.step   = (state_reg == S_SCAN);
        scan_ctl.alloc  = is_alloc;
        scan_ctl.active = (CntW'(cnt_reg) < n_eff);
    end

    pfa_scan #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (scan_ctl),
        .policy     (policy_reg),
        .size       (size_reg),
        .idx        (cnt_reg),
        .head_left  (cell_left[0]),
        .head_taken (cell_taken[0]),
        .found      (found),
        .best_idx   (best_idx),
        .best_left  (best_left),
        .sum        (sum)
    );

    // The chosen block was free and in range, so drop its original size
    assign ext_exact = ExtCalcW'(sum)
                     - ((is_alloc && found)
                        ? (ExtCalcW'(best_left) + ExtCalcW'(size_reg))
                        : ExtCalcW'(0));
    assign ext_sat = (ext_exact > ExtCalcW'(EXT_MAX)) ? EXT_MAX : ext_exact[EXT_W-1:0];

    assign int_sum = {1'b0, internal_reg} + (INT_W + 1)'(best_left);
    assign int_sat = int_sum[INT_W] ? INT_MAX : int_sum[INT_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        next_id_next   = next_id_reg;
        internal_next  = internal_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (req_acc)
                begin
                    state_next = S_SCAN;
                    cnt_next   = '0;
                    if (req.kind == KIND_ALLOC)
                    begin
                        next_id_next = next_id_reg + 1'b1;
                    end
                end
            end
            S_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CntLast)
                begin
                    state_next = S_DONE;
                    cnt_next   = '0;
                end
            end
            S_DONE:
            begin
                if (done_fire)
                begin
                    state_next     = S_IDLE;
                    rsp_valid_next = 1'b1;
                    if (fin_wr)
                    begin
                        internal_next = int_sat;
                    end
                    rsp_next.internal_frag = fin_wr ? int_sat : internal_reg;
                    rsp_next.external_frag = ext_sat;
                    if (!is_alloc)
                    begin
                        rsp_next.status       = STATUS_LOADED;
                        rsp_next.chosen_block = bidx_reg;
                        rsp_next.process_id   = '0;
                    end
                    else if (found)
                    begin
                        rsp_next.status       = STATUS_ALLOC;
                        rsp_next.chosen_block = BLOCK_INDEX_W'(best_idx);
                        rsp_next.process_id   = pid_reg;
                    end
                    else
                    begin
                        rsp_next.status       = STATUS_NOFIT;
                        rsp_next.chosen_block = '0;
                        rsp_next.process_id   = pid_reg;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        policy_next = policy_reg;
        bcount_next = bcount_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_POLICY:      policy_next = cfg_data[POLICY_W-1:0];
                CFG_BLOCK_COUNT: bcount_next = cfg_data[BCOUNT_W-1:0];
                default:         policy_next = policy_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            next_id_reg   <= PID_RESET;
            internal_reg  <= '0;
            policy_reg    <= POLICY_BEST;
            bcount_reg    <= BCOUNT_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            next_id_reg   <= next_id_next;
            internal_reg  <= internal_next;
            policy_reg    <= policy_next;
            bcount_reg    <= bcount_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Hold the request fields for the whole scan
    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            kind_reg <= req.kind;
            bidx_reg <= req.block_index;
            size_reg <= req.size;
            pid_reg  <= next_id_reg;
        end
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `ASSERT_NEXT(a_accept_scan, clk, rst_n, req_acc, state_reg == S_SCAN, "accepted request did not start a scan")
    `ASSERT_NEXT(a_cnt_step, clk, rst_n, (state_reg == S_SCAN) && (cnt_reg != CntLast), cnt_reg == $past(cnt_reg) + 1'b1, "ring position skipped during scan")
    `ASSERT_NEXT(a_id_hold, clk, rst_n, !(req_acc && (req.kind == KIND_ALLOC)), $stable(next_id_reg), "process id moved without an allocate request")
    `ASSERT_NEXT(a_int_grow, clk, rst_n, 1'b1, internal_reg >= $past(internal_reg), "internal fragmentation total decreased")

endmodule

// File: design/pfa_cell.sv
// ----------------------------------------------------------------------------
// pfa_cell
// One block of the ring: remaining size and owned flag, rotated to the
// neighbouring cell on every shift.
// ----------------------------------------------------------------------------
module pfa_cell
    import pfa_pkg::*;
#(
    parameter int SIZE_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cell_cmd_t            cmd,
    input  logic [SIZE_BITS-1:0] wr_left,
    input  logic [SIZE_BITS-1:0] prev_left,
    input  logic                 prev_taken,
    output logic [SIZE_BITS-1:0] left,
    output logic                 taken
);

    logic [SIZE_BITS-1:0] left_reg;
    logic [SIZE_BITS-1:0] left_next;
    logic                 taken_reg;
    logic                 taken_next;

    always_comb
    begin
        left_next  = left_reg;
        taken_next = taken_reg;
        if (cmd.wr_en)
        begin
            left_next  = wr_left;
            taken_next = cmd.wr_taken;
        end
        else if (cmd.shift)
        begin
            left_next  = prev_left;
            taken_next = prev_taken;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg <= left_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taken_reg <= 1'b0;
        end
        else
        begin
            taken_reg <= taken_next;
        end
    end

    assign left  = left_reg;
    assign taken = taken_reg;

endmodule

// File: design/pfa_scan.sv
// ----------------------------------------------------------------------------
// pfa_scan
// Head-of-ring evaluator: keeps the running choice of block under the
// placement policy and the sum of free block sizes.
// ----------------------------------------------------------------------------
module pfa_scan
    import pfa_pkg::*;
#(
    parameter int NUM_BLOCKS = 64,
    parameter int SIZE_BITS  = 16
)
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  scan_ctl_t                                 ctl,
    input  logic [POLICY_W-1:0]                       policy,
    input  logic [REQ_SIZE_W-1:0]                     size,
    input  logic [$clog2(NUM_BLOCKS)-1:0]             idx,
    input  logic [SIZE_BITS-1:0]                      head_left,
    input  logic                                      head_taken,
    output logic                                      found,
    output logic [$clog2(NUM_BLOCKS)-1:0]             best_idx,
    output logic [SIZE_BITS-1:0]                      best_left,
    output logic [SIZE_BITS+$clog2(NUM_BLOCKS)-1:0]   sum
);

    localparam int IdxW = $clog2(NUM_BLOCKS);
    localparam int SumW = SIZE_BITS + IdxW;
    localparam int CmpW = (SIZE_BITS > REQ_SIZE_W) ? SIZE_BITS : REQ_SIZE_W;

    logic                 found_reg;
    logic                 found_next;
    logic [IdxW-1:0]      best_idx_reg;
    logic [IdxW-1:0]      best_idx_next;
    logic [SIZE_BITS-1:0] best_left_reg;
    logic [SIZE_BITS-1:0] best_left_next;
    logic [SumW-1:0]      sum_reg;
    logic [SumW-1:0]      sum_next;

    logic                 is_free;
    logic                 fits;
    logic [SIZE_BITS-1:0] leftover;
    logic                 take;

    assign is_free  = ctl.active && !head_taken;
    assign fits     = ctl.alloc && is_free && (CmpW'(head_left) >= CmpW'(size));
    assign leftover = head_left - SIZE_BITS'(size);

    always_comb
    begin
        case (policy)
            POLICY_BEST:  take = !found_reg || (leftover <= best_left_reg);
            POLICY_WORST: take = !found_reg || (leftover >= best_left_reg);
            default:      take = !found_reg;
        endcase
    end

    always_comb
    begin
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_left_next = best_left_reg;
        sum_next       = sum_reg;
        if (ctl.clear)
        begin
            found_next     = 1'b0;
            best_idx_next  = '0;
            best_left_next = '0;
            sum_next       = '0;
        end
        else if (ctl.step)
        begin
            if (fits && take)
            begin
                found_next     = 1'b1;
                best_idx_next  = idx;
                best_left_next = leftover;
            end
            if (is_free)
            begin
                sum_next = sum_reg + SumW'(head_left);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_idx_reg  <= best_idx_next;
        best_left_reg <= best_left_next;
        sum_reg       <= sum_next;
    end

    assign found     = found_reg;
    assign best_idx  = best_idx_reg;
    assign best_left = best_left_reg;
    assign sum       = sum_reg;

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for partition_fit_allocator_core. A directed table
// covers the corner cases, then random load and allocate traffic runs under
// several policy and block-count settings, with random sender gaps, receiver
// stalls and one long receiver hold-off. Each response is compared field by
// field to the in-bench table model or to a directed row's fixed response.
// ----------------------------------------------------------------------------
module tb_top;
    import pfa_pkg::*;

    localparam int NBLK         = 64;
    localparam int PLAN_LEN     = 26;
    localparam int PHASES       = 9;
    localparam int PHASE_ITEMS  = 100;
    localparam int QUIET_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 500;

    localparam logic [POLICY_W-1:0] POLICY_FIRST     = 2'd2;
    localparam logic [POLICY_W-1:0] POLICY_FIRST_ALT = 2'd3;

    typedef struct packed {
        logic fixed;
        rsp_t val;
    } known_rsp_t;

    typedef struct packed {
        logic                  is_cfg;
        req_t                  item;
        known_rsp_t            known;
        logic [CFG_DATA_W-1:0] pol;
        logic [CFG_DATA_W-1:0] cnt;
    } plan_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   req_valid = 1'b0;
    logic                   req_stall;
    req_t                   req = '0;
    logic                   rsp_valid;
    logic                   rsp_stall = 1'b0;
    rsp_t                   rsp;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Model of the block table
    logic [REQ_SIZE_W-1:0] blk_size [NBLK];
    logic                  blk_owned [NBLK];
    logic [PID_W-1:0]      pid_next = PID_RESET;
    logic [INT_W-1:0]      frag_int = '0;
    logic [POLICY_W-1:0]   sel_policy = POLICY_BEST;
    logic [BCOUNT_W-1:0]   sel_count = BCOUNT_RESET;

    known_rsp_t typed_rsp_q [$];
    rsp_t       due_rsp_q [$];
    rsp_t       predicted;
    rsp_t       want;
    known_rsp_t tag;

    int unsigned bad_count = 0;
    int unsigned served = 0;
    int unsigned quiet_cycles = 0;
    int unsigned burst_left = 0;

    plan_row_t plan [PLAN_LEN];

    partition_fit_allocator_core #(
        .NUM_BLOCKS (NBLK),
        .SIZE_BITS  (REQ_SIZE_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        for (int i = 0; i < NBLK; i++)
        begin
            blk_owned[i] = 1'b0;
            blk_size[i]  = '0;
        end
    end

    // Apply one transaction to the table and return the response it yields
    function automatic rsp_t place_request(input req_t r);
        rsp_t                  o;
        int unsigned           lim;
        int unsigned           esum;
        bit                    hit;
        logic [BLOCK_INDEX_W-1:0] pick;
        logic [REQ_SIZE_W-1:0] pick_left;
        logic [REQ_SIZE_W-1:0] rest;
        logic [INT_W:0]        isum;
        o = '0;
        lim = (sel_count > NBLK) ? NBLK : sel_count;
        if (r.kind == KIND_LOAD)
        begin
            blk_size[r.block_index]  = r.size;
            blk_owned[r.block_index] = 1'b0;
            o.status       = STATUS_LOADED;
            o.chosen_block = r.block_index;
        end
        else
        begin
            o.process_id = pid_next;
            pid_next     = pid_next + 1'b1;
            hit          = 1'b0;
            pick         = '0;
            pick_left    = '0;
            for (int unsigned k = 0; k < lim; k++)
            begin
                if (!blk_owned[k] && blk_size[k] >= r.size)
                begin
                    rest = blk_size[k] - r.size;
                    // ties go to the later block for best and worst fit
                    if (sel_policy == POLICY_BEST)
                    begin
                        if (!hit || rest <= pick_left)
                        begin
                            hit = 1'b1; pick = k[BLOCK_INDEX_W-1:0]; pick_left = rest;
                        end
                    end
                    else if (sel_policy == POLICY_WORST)
                    begin
                        if (!hit || rest >= pick_left)
                        begin
                            hit = 1'b1; pick = k[BLOCK_INDEX_W-1:0]; pick_left = rest;
                        end
                    end
                    else if (!hit)
                    begin
                        hit = 1'b1; pick = k[BLOCK_INDEX_W-1:0]; pick_left = rest;
                    end
                end
            end
            if (hit)
            begin
                blk_owned[pick] = 1'b1;
                blk_size[pick]  = pick_left;
                isum            = {1'b0, frag_int} + pick_left;
                frag_int        = isum[INT_W] ? INT_MAX : isum[INT_W-1:0];
                o.status        = STATUS_ALLOC;
                o.chosen_block  = pick;
            end
            else
                o.status = STATUS_NOFIT;
        end
        o.internal_frag = frag_int;
        esum = 0;
        for (int unsigned k = 0; k < lim; k++)
            if (!blk_owned[k])
                esum += blk_size[k];
        o.external_frag = (esum > EXT_MAX) ? EXT_MAX : esum[EXT_W-1:0];
        return o;
    endfunction

    // Monitor: follow every handshake at the clock edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_POLICY)
                    sel_policy = cfg_data[POLICY_W-1:0];
                else
                    sel_count = cfg_data[BCOUNT_W-1:0];
            end
            if (req_valid && !req_stall)
            begin
                predicted = place_request(req);
                tag = typed_rsp_q.pop_front();
                due_rsp_q.push_back(tag.fixed ? tag.val : predicted);
            end
            if (rsp_valid && !rsp_stall)
            begin
                served++;
                if (due_rsp_q.size() == 0)
                begin
                    if (bad_count < 10)
                        $display("[%0t] response with nothing outstanding: st=%0d blk=%0d",
                                 $time, rsp.status, rsp.chosen_block);
                    bad_count++;
                end
                else
                begin
                    want = due_rsp_q.pop_front();
                    if (rsp.status !== want.status || rsp.chosen_block !== want.chosen_block ||
                        rsp.process_id !== want.process_id ||
                        rsp.internal_frag !== want.internal_frag ||
                        rsp.external_frag !== want.external_frag)
                    begin
                        if (bad_count < 10)
                            $display({"[%0t] response mismatch: want st=%0d blk=%0d pid=%0d ",
                                      "int=%0d ext=%0d, got st=%0d blk=%0d pid=%0d int=%0d ext=%0d"},
                                     $time, want.status, want.chosen_block, want.process_id,
                                     want.internal_frag, want.external_frag, rsp.status,
                                     rsp.chosen_block, rsp.process_id, rsp.internal_frag,
                                     rsp.external_frag);
                        bad_count++;
                    end
                end
            end
        end
    end

    // Watchdog: end the run when no channel moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    // Receiver: stall patterns, plus one long hold-off to back the block up
    initial
    begin : rsp_side
        int unsigned mode;
        int unsigned span;
        int unsigned tick;
        bit          held;
        held = 1'b0;
        tick = 0;
        wait (rst_n);
        forever
        begin
            if (!held && served >= 200)
            begin
                held = 1'b1;
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 150);
            repeat (span)
            begin
                case (mode)
                    0: rsp_stall <= 1'b0;
                    1: rsp_stall <= ($urandom_range(0, 99) < 30);
                    2: rsp_stall <= ($urandom_range(0, 99) < 80);
                    default: rsp_stall <= ((tick % 5) < 2);
                endcase
                tick++;
                @(posedge clk);
            end
        end
    end

    function automatic logic [REQ_SIZE_W-1:0] draw_size(input bit for_alloc);
        int unsigned v;
        case ($urandom_range(0, 3))
            0: v = $urandom_range(0, 65535);
            1: v = 64 * $urandom_range(0, 8);
            2: v = for_alloc ? $urandom_range(0, 511) : $urandom_range(0, 1023);
            default: v = $urandom_range(0, 1) ? 65535 : 0;
        endcase
        return v[REQ_SIZE_W-1:0];
    endfunction

    function automatic req_t draw_item(input int unsigned lim);
        req_t r;
        r.kind = ($urandom_range(0, 9) < 6) ? KIND_ALLOC : KIND_LOAD;
        // aim most loads at blocks inside the searched range
        if (lim != 0 && $urandom_range(0, 3) != 0)
            r.block_index = BLOCK_INDEX_W'($urandom_range(0, lim - 1));
        else
            r.block_index = BLOCK_INDEX_W'($urandom_range(0, NBLK - 1));
        r.size = draw_size(r.kind == KIND_ALLOC);
        return r;
    endfunction

    function automatic plan_row_t mk_item(input logic [KIND_W-1:0] kind,
                                          input int unsigned idx, input int unsigned sz);
        plan_row_t row;
        row = '0;
        row.item.kind        = kind;
        row.item.block_index = BLOCK_INDEX_W'(idx);
        row.item.size        = REQ_SIZE_W'(sz);
        return row;
    endfunction

    function automatic plan_row_t mk_known(input logic [KIND_W-1:0] kind,
                                           input int unsigned idx, input int unsigned sz,
                                           input logic [STATUS_W-1:0] st,
                                           input int unsigned blk, input int unsigned pid);
        plan_row_t row;
        row = mk_item(kind, idx, sz);
        row.known.fixed            = 1'b1;
        row.known.val.status       = st;
        row.known.val.chosen_block = BLOCK_INDEX_W'(blk);
        row.known.val.process_id   = PID_W'(pid);
        return row;
    endfunction

    function automatic plan_row_t mk_cfg(input logic [POLICY_W-1:0] pol,
                                         input int unsigned cnt);
        plan_row_t row;
        row = '0;
        row.is_cfg = 1'b1;
        row.pol    = CFG_DATA_W'(pol);
        row.cnt    = CFG_DATA_W'(cnt);
        return row;
    endfunction

    // Offer one transaction; the sender runs in bursts with gaps between
    task automatic offer(input req_t r, input known_rsp_t known);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
            if (gap != 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        typed_rsp_q.push_back(known);
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    // Wait until every response is in, then let the scan finish
    task automatic drain();
        req_valid <= 1'b0;
        burst_left = 0;
        while (due_rsp_q.size() != 0 || typed_rsp_q.size() != 0)
            @(posedge clk);
        repeat (NBLK + 4) @(posedge clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] pol,
                             input logic [CFG_DATA_W-1:0] cnt);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_POLICY;
        cfg_data  <= pol;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= CFG_BLOCK_COUNT;
        cfg_data  <= cnt;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        int unsigned           n;
        int unsigned           lim;
        logic [POLICY_W-1:0]   pol;
        logic [CFG_DATA_W-1:0] pol_data;
        logic [CFG_DATA_W-1:0] cnt_data;
        req_t                  r;

        plan = '{
            // block count zero: nothing searched, nothing summed
            mk_known(KIND_ALLOC, 0, 0, STATUS_NOFIT, 0, 1),
            mk_known(KIND_LOAD, 63, 65535, STATUS_LOADED, 63, 0),
            mk_known(KIND_LOAD, 0, 100, STATUS_LOADED, 0, 0),
            mk_known(KIND_LOAD, 1, 50, STATUS_LOADED, 1, 0),
            mk_known(KIND_LOAD, 2, 100, STATUS_LOADED, 2, 0),
            mk_known(KIND_LOAD, 3, 50, STATUS_LOADED, 3, 0),
            mk_cfg(POLICY_BEST, 4),
            mk_item(KIND_ALLOC, 0, 50),
            mk_item(KIND_ALLOC, 0, 50),
            mk_item(KIND_ALLOC, 0, 60),
            mk_item(KIND_ALLOC, 0, 65535),
            mk_cfg(POLICY_WORST, 4),
            mk_item(KIND_LOAD, 1, 300),
            mk_item(KIND_LOAD, 3, 300),
            mk_item(KIND_ALLOC, 0, 0),
            mk_cfg(POLICY_FIRST, 4),
            mk_item(KIND_ALLOC, 0, 0),
            mk_item(KIND_ALLOC, 0, 301),
            // unused policy code and an over-range count
            mk_cfg(POLICY_FIRST_ALT, 127),
            mk_item(KIND_ALLOC, 0, 65535),
            mk_item(KIND_LOAD, 2, 0),
            mk_item(KIND_ALLOC, 0, 0),
            mk_cfg(POLICY_BEST, 1),
            mk_item(KIND_ALLOC, 0, 1),
            mk_cfg(POLICY_WORST, 64),
            mk_item(KIND_ALLOC, 0, 0)
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill every block while none is searched, so no read sees an unwritten one
        configure(CFG_DATA_W'(POLICY_BEST), '0);
        for (n = 0; n < NBLK; n++)
        begin
            r.kind        = KIND_LOAD;
            r.block_index = BLOCK_INDEX_W'(n);
            r.size        = draw_size(1'b0);
            offer(r, '0);
        end

        for (n = 0; n < PLAN_LEN; n++)
        begin
            if (plan[n].is_cfg)
            begin
                drain();
                configure(plan[n].pol, plan[n].cnt);
            end
            else
                offer(plan[n].item, plan[n].known);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: begin pol = POLICY_BEST;      cnt_data = 7'd64;  end
                1: begin pol = POLICY_WORST;     cnt_data = 7'd1;   end
                2: begin pol = POLICY_FIRST;     cnt_data = 7'd127; end
                3: begin pol = POLICY_FIRST_ALT; cnt_data = 7'd0;   end
                default:
                begin
                    pol = POLICY_W'($urandom_range(0, 3));
                    if ($urandom_range(0, 4) == 0)
                        cnt_data = CFG_DATA_W'($urandom_range(65, 127));
                    else
                        cnt_data = CFG_DATA_W'($urandom_range(1, 64));
                end
            endcase
            // upper data bits of the policy write are don't-care
            pol_data = (ph < 4) ? CFG_DATA_W'(pol) : CFG_DATA_W'({$urandom_range(0, 31), pol});
            drain();
            configure(pol_data, cnt_data);
            lim = (cnt_data > NBLK) ? NBLK : cnt_data;
            for (n = 0; n < PHASE_ITEMS; n++)
                offer(draw_item(lim), '0);
        end

        drain();
        if (bad_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
